/* hdl/lcdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdr_pkg
// Types, codes and control store for the character LCD refresh controller.
// ----------------------------------------------------------------------------
package lcdr_pkg;

  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] pc_t;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;

  localparam pc_t STEP_IDLE    = 4'd0;
  localparam pc_t STEP_WRITE   = 4'd1;
  localparam pc_t STEP_RF      = 4'd2;
  localparam pc_t STEP_RF_CMD  = 4'd3;
  localparam pc_t STEP_RF_DATA = 4'd4;
  localparam pc_t STEP_RF_NEXT = 4'd5;
  localparam pc_t STEP_RF_ROW1 = 4'd6;
  localparam pc_t STEP_INIT    = 4'd7;

  typedef struct packed {
    logic [1:0] operation;
    logic       row;
    logic [3:0] column;
    logic [7:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_value;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_ROW_CMD,
    SRC_MEM
  } src_t;

  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ALWAYS,
    LAST_ROW_END
  } last_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_ROW0,
    ACT_ROW1,
    ACT_COL_CLR,
    ACT_COL_INC
  } act_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_SKIP_ROW0,
    COND_COL_MORE,
    COND_ROWS_DONE
  } cond_t;

  typedef struct packed {
    logic       emit;
    logic       rs;
    src_t       src;
    logic [7:0] cbyte;
    last_t      last_kind;
    act_t       act;
    cond_t      cond;
    pc_t        target;
  } uword_t;

  typedef struct packed {
    logic wr_col_ok;
    logic snap0;
    logic rows_done;
    logic col_end;
  } flags_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_NONE, COND_DISPATCH, STEP_IDLE};
      4'd1:  w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_WRITE, COND_ALWAYS, STEP_IDLE};
      4'd2:  w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_ROW0, COND_SKIP_ROW0,
                   STEP_RF_NEXT};
      4'd3:  w = '{1'b1, 1'b0, SRC_ROW_CMD, 8'h00, LAST_NONE, ACT_COL_CLR, COND_NEXT,
                   STEP_IDLE};
      4'd4:  w = '{1'b1, 1'b1, SRC_MEM, 8'h00, LAST_ROW_END, ACT_COL_INC, COND_COL_MORE,
                   STEP_RF_DATA};
      4'd5:  w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_NONE, COND_ROWS_DONE,
                   STEP_IDLE};
      4'd6:  w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_ROW1, COND_ALWAYS,
                   STEP_RF_CMD};
      4'd7:  w = '{1'b1, 1'b0, SRC_CONST, CMD_FUNC_SET, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd8:  w = '{1'b1, 1'b0, SRC_CONST, CMD_FUNC_SET, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd9:  w = '{1'b1, 1'b0, SRC_CONST, CMD_FUNC_SET, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd10: w = '{1'b1, 1'b0, SRC_CONST, CMD_FUNC_SET, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd11: w = '{1'b1, 1'b0, SRC_CONST, CMD_DISP_ON, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd12: w = '{1'b1, 1'b0, SRC_CONST, CMD_CLEAR, LAST_NONE, ACT_NONE, COND_NEXT,
                   STEP_IDLE};
      4'd13: w = '{1'b1, 1'b0, SRC_CONST, CMD_ENTRY, LAST_ALWAYS, ACT_NONE, COND_ALWAYS,
                   STEP_IDLE};
      default: w = '{1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NONE, ACT_NONE, COND_ALWAYS,
                     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hdl/lcdr_useq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdr_useq
// Step counter and control store: fetches one control word per cycle and
// resolves dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module lcdr_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [1:0]      operation,
  input  wire lcdr_pkg::flags_t flags,
  output lcdr_pkg::uword_t     uw,
  output logic                 busy
);

  lcdr_pkg::pc_t pc;
  lcdr_pkg::pc_t pc_next;
  lcdr_pkg::pc_t pc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lcdr_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_inc  = pc + lcdr_pkg::pc_t'(1);
    pc_next = pc_inc;
    unique case (uw.cond)
      lcdr_pkg::COND_NEXT:   pc_next = pc_inc;
      lcdr_pkg::COND_ALWAYS: pc_next = uw.target;
      lcdr_pkg::COND_DISPATCH: begin
        pc_next = lcdr_pkg::STEP_IDLE;
        if (accept) begin
          unique case (operation)
            lcdr_pkg::OP_WRITE:   pc_next = flags.wr_col_ok ? lcdr_pkg::STEP_WRITE
                                                            : lcdr_pkg::STEP_IDLE;
            lcdr_pkg::OP_REFRESH: pc_next = lcdr_pkg::STEP_RF;
            lcdr_pkg::OP_INIT:    pc_next = lcdr_pkg::STEP_INIT;
            default:              pc_next = lcdr_pkg::STEP_IDLE;
          endcase
        end
      end
      lcdr_pkg::COND_SKIP_ROW0: pc_next = flags.snap0 ? pc_inc : uw.target;
      lcdr_pkg::COND_COL_MORE:  pc_next = flags.col_end ? pc_inc : uw.target;
      lcdr_pkg::COND_ROWS_DONE: pc_next = flags.rows_done ? uw.target : pc_inc;
      default:                  pc_next = lcdr_pkg::STEP_IDLE;
    endcase
  end

  always_comb begin
    uw   = lcdr_pkg::ucode_rom(pc);
    busy = (pc != lcdr_pkg::STEP_IDLE);
  end

endmodule
`default_nettype wire

/* hdl/lcdr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdr_datapath
// Shadow buffer, dirty and text-end state, column counter and bus output
// register, driven by the control word.
// ----------------------------------------------------------------------------
module lcdr_datapath #(
  parameter int COLUMNS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire lcdr_pkg::cmd_t    cmd,
  input  wire lcdr_pkg::uword_t  uw,
  output lcdr_pkg::flags_t       flags,
  output lcdr_pkg::result_t      result,
  output logic                   result_strobe
);

  localparam int DEPTH = 2 * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [7:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]    rdata;
  logic          rvalid;

  logic [1:0]    row_dirty;
  logic [1:0]    snap;
  logic          text_ended;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_byte;
  logic          wr_row;
  logic          row_sel;
  logic [CW-1:0] col;

  logic [AW-1:0] in_addr;
  logic [AW-1:0] row_base;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic          col_ok;
  logic          te_eff;
  logic [7:0]    stored;
  logic [7:0]    old_byte;
  logic          changed;
  logic          col_end;
  logic          rows_done;

  always_comb begin
    col_ok    = {2'b00, cmd.column} < 6'(COLUMNS);
    in_addr   = (cmd.row ? AW'(COLUMNS) : '0) + AW'(cmd.column);
    row_base  = row_sel ? AW'(COLUMNS) : '0;
    te_eff    = (cmd.column == 4'd0) ? 1'b0 : text_ended;
    stored    = (te_eff || cmd.char_code == 8'h00) ? lcdr_pkg::SPACE_CHAR : cmd.char_code;
    old_byte  = rvalid ? rdata : lcdr_pkg::SPACE_CHAR;
    changed   = (old_byte != wr_byte);
    col_end   = (col == CW'(COLUMNS - 1));
    rows_done = row_sel || !snap[1];
    unique case (uw.act)
      lcdr_pkg::ACT_COL_CLR: rd_addr = row_base;
      lcdr_pkg::ACT_COL_INC: rd_addr = row_base + AW'(col) + AW'(1);
      default:               rd_addr = in_addr;
    endcase
    rd_in_range = {1'b0, rd_addr} < (AW + 1)'(DEPTH);
    flags.wr_col_ok = col_ok;
    flags.snap0     = snap[0];
    flags.rows_done = rows_done;
    flags.col_end   = col_end;
  end

  // shadow buffer
  always_ff @(posedge clk) begin
    if (uw.act == lcdr_pkg::ACT_WRITE && changed) begin
      mem[wr_addr] <= wr_byte;
    end
    if (rd_in_range) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (uw.act == lcdr_pkg::ACT_WRITE && changed) begin
        valid[wr_addr] <= 1'b1;
      end
      rvalid <= rd_in_range ? valid[rd_addr] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_dirty  <= 2'b11;
      snap       <= 2'b00;
      text_ended <= 1'b0;
      row_sel    <= 1'b0;
      col        <= '0;
    end else begin
      if (accept && cmd.operation == lcdr_pkg::OP_WRITE && col_ok) begin
        text_ended <= (cmd.char_code == 8'h00) ? 1'b1 : te_eff;
      end
      if (accept && cmd.operation == lcdr_pkg::OP_REFRESH) begin
        snap      <= row_dirty;
        row_dirty <= 2'b00;
      end
      unique case (uw.act)
        lcdr_pkg::ACT_WRITE: begin
          if (changed) begin
            row_dirty[wr_row] <= 1'b1;
          end
        end
        lcdr_pkg::ACT_ROW0:    row_sel <= 1'b0;
        lcdr_pkg::ACT_ROW1:    row_sel <= 1'b1;
        lcdr_pkg::ACT_COL_CLR: col <= '0;
        lcdr_pkg::ACT_COL_INC: col <= col + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr <= in_addr;
      wr_byte <= stored;
      wr_row  <= cmd.row;
    end
  end

  // bus output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= uw.emit;
    end
  end

  always_ff @(posedge clk) begin
    result.register_select <= uw.rs;
    unique case (uw.src)
      lcdr_pkg::SRC_ROW_CMD:
        result.bus_value <= lcdr_pkg::CMD_SET_ADDR | (row_sel ? lcdr_pkg::ROW1_OFFSET : 8'h00);
      lcdr_pkg::SRC_MEM: result.bus_value <= old_byte;
      default:           result.bus_value <= uw.cbyte;
    endcase
    unique case (uw.last_kind)
      lcdr_pkg::LAST_ALWAYS:  result.last <= 1'b1;
      lcdr_pkg::LAST_ROW_END: result.last <= col_end && rows_done;
      default:                result.last <= 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/char_lcd_refresh_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_refresh_controller
// Two-row character LCD shadow buffer with microcoded refresh and init runs.
// ----------------------------------------------------------------------------
// One control word per cycle sets all timing. Write: busy for the write step; a column
//   of COLUMNS or more is ignored. Refresh: per dirty row a row command then COLUMNS data
//   words, with the row-check and row-1 steps emitting nothing between rows; with no row
//   dirty the run emits nothing.
// Init: 7 command words on consecutive cycles, the last one flagged as last.
// Sync reset: buffer reads as spaces, both rows dirty, sequencer idle; receiver cannot stall.
module char_lcd_refresh_controller #(
  parameter int COLUMNS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lcdr_pkg::cmd_t    command,
  output logic                   busy,
  output lcdr_pkg::result_t      result,
  output logic                   result_strobe
);

  logic              accept;
  lcdr_pkg::uword_t  uw;
  lcdr_pkg::flags_t  flags;

  assign accept = start && !busy;

  lcdr_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (command.operation),
    .flags     (flags),
    .uw        (uw),
    .busy      (busy)
  );

  lcdr_datapath #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (command),
    .uw            (uw),
    .flags         (flags),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
`default_nettype wire

/* hdl/lcdr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdr_checker
// Port-level checks on result sequencing of the LCD refresh controller.
// ----------------------------------------------------------------------------
module lcdr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire lcdr_pkg::result_t result,
  input wire logic              result_strobe
);

  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result word outside a run");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("result word right after last");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_strobe)
    else $error("result word one cycle after acceptance");

  a_open_run_busy: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |-> busy)
    else $error("run not finished but controller idle");

  a_addr_then_data: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.register_select && result.bus_value[7])
      |=> (result_strobe && result.register_select))
    else $error("row address not followed by data");

endmodule

bind char_lcd_refresh_controller lcdr_checker u_lcdr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);
`default_nettype wire
